// File: rtl/repose_slope_slide_transfer_unit_assert.svh
// assertion macros for the slide transfer unit
// no dependencies; taken in by files that carry concurrent assertions
`ifndef REPOSE_SLOPE_SLIDE_TRANSFER_UNIT_ASSERT_SVH
`define REPOSE_SLOPE_SLIDE_TRANSFER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RSST_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RSST_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSST_ASSERT_RST(label, clk, rst, prop, msg)
`define RSST_ASSERT(label, clk, prop, msg)
`endif
`endif

// File: rtl/rsst_pkg.sv
`timescale 1ns / 1ps
// shared widths, constants and types of the slide transfer unit
// no dependencies
package rsst_pkg;

   localparam int NUM_NEIGHBORS  = 8;
   localparam int DIR_W          = 3;
   localparam int HEIGHT_W       = 32;
   localparam int DZ_W           = 32;
   localparam int FRAC_SHIFT     = 30;
   localparam int KEY_W          = DZ_W + FRAC_SHIFT;
   localparam int TAN_W          = 16;
   localparam int TAN_FRAC       = 12;
   localparam int SPACING_W      = 31;
   localparam int DIST_W         = 32;
   localparam int PROD_W         = TAN_W + DIST_W;
   localparam int EXCESS_W       = PROD_W + 1;
   localparam int TRANSFER_SHIFT = 14;
   localparam int AMOUNT_W       = 31;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_INDEX_W    = 2;
   localparam int SPACING_PROD_W = SPACING_W + FRAC_SHIFT + 1;

   localparam logic [FRAC_SHIFT-1:0]   INV_SQRT2_Q30 = 30'd759250125;
   localparam logic [FRAC_SHIFT:0]     SQRT2_Q30     = 31'd1518500250;
   localparam logic [NUM_NEIGHBORS-1:0] DIAG_MASK    = 8'b1010_0101;

   localparam logic [SPACING_W-1:0]       SPACING_RESET    = 31'd65536;
   localparam logic signed [HEIGHT_W-1:0] ZONE_START_RESET = 32'sh8000_0000;
   localparam logic signed [HEIGHT_W-1:0] ZONE_END_RESET   = 32'sh7fff_ffff;

   // pipeline stage positions
   localparam int S_DZ       = 0;
   localparam int S_KEY      = 1;
   localparam int S_L1       = 2;
   localparam int S_L2       = 3;
   localparam int S_L3       = 4;
   localparam int S_MUL      = 5;
   localparam int S_OUT      = 6;
   localparam int NUM_STAGES = 7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_SPACING = 2'd0,
      CSR_ZONE_START   = 2'd1,
      CSR_ZONE_END     = 2'd2
   } csr_index_type;

   typedef logic signed [HEIGHT_W-1:0] height_type;
   typedef logic [DZ_W-1:0]            dz_type;
   typedef logic [KEY_W-1:0]           key_type;
   typedef logic [DIR_W-1:0]           dir_type;
   typedef logic [TAN_W-1:0]           tan_type;

   typedef struct packed {
      key_type key;
      dz_type  dz;
      dir_type idx;
   } cand_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

endpackage

// File: rtl/rsst_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces of the slide transfer unit
// depends on rsst_pkg
interface rsst_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rsst_pkg::HEIGHT_W-1:0]  center_height;
   logic signed [rsst_pkg::HEIGHT_W-1:0]  neighbor_0;
   logic signed [rsst_pkg::HEIGHT_W-1:0]  neighbor_1;
   logic signed [rsst_pkg::HEIGHT_W-1:0]  neighbor_2;
   logic signed [rsst_pkg::HEIGHT_W-1:0]  neighbor_3;
   logic signed [rsst_pkg::HEIGHT_W-1:0]  neighbor_4;
   logic signed [rsst_pkg::HEIGHT_W-1:0]  neighbor_5;
   logic signed [rsst_pkg::HEIGHT_W-1:0]  neighbor_6;
   logic signed [rsst_pkg::HEIGHT_W-1:0]  neighbor_7;
   logic [rsst_pkg::NUM_NEIGHBORS-1:0]    neighbor_valid;
   logic [rsst_pkg::TAN_W-1:0]            tan_slope;
   logic signed [rsst_pkg::HEIGHT_W-1:0]  cell_x;

   modport source (
      output valid, center_height, neighbor_0, neighbor_1, neighbor_2, neighbor_3,
             neighbor_4, neighbor_5, neighbor_6, neighbor_7, neighbor_valid,
             tan_slope, cell_x,
      input  ready
   );
   modport sink (
      input  valid, center_height, neighbor_0, neighbor_1, neighbor_2, neighbor_3,
             neighbor_4, neighbor_5, neighbor_6, neighbor_7, neighbor_valid,
             tan_slope, cell_x,
      output ready
   );
endinterface

interface rsst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          slid;
   logic [rsst_pkg::DIR_W-1:0]    direction;
   logic [rsst_pkg::AMOUNT_W-1:0] transfer_amount;

   modport source (
      output valid, slid, direction, transfer_amount,
      input  ready
   );
   modport sink (
      input  valid, slid, direction, transfer_amount,
      output ready
   );
endinterface

// File: rtl/rsst_pipe_ctrl.sv
`timescale 1ns / 1ps
// stage valid bits and per-stage load enables of the slide transfer pipeline
// depends on rsst_pkg
module rsst_pipe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    out_ready,
   output rsst_pkg::pipe_ctrl_type ctrl
);

   logic [rsst_pkg::NUM_STAGES-1:0] valid_ff;
   logic [rsst_pkg::NUM_STAGES-1:0] valid_in;
   logic [rsst_pkg::NUM_STAGES-1:0] load;

   // a stage loads when empty or when its content moves on
   always_comb begin
      load[rsst_pkg::NUM_STAGES-1] = !valid_ff[rsst_pkg::NUM_STAGES-1] || out_ready;
      for (int i = rsst_pkg::NUM_STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < rsst_pkg::NUM_STAGES; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load  = load;
   assign ctrl.valid = valid_ff;

endmodule

// File: rtl/rsst_key_gen.sv
`timescale 1ns / 1ps
// height drops, zone test and steepness keys for the eight neighbours
// depends on rsst_pkg
module rsst_key_gen (
   input  logic                          clock,
   input  rsst_pkg::pipe_ctrl_type       ctrl,
   input  rsst_pkg::height_type          center_height,
   input  rsst_pkg::height_type          neighbor [rsst_pkg::NUM_NEIGHBORS],
   input  logic [rsst_pkg::NUM_NEIGHBORS-1:0] neighbor_valid,
   input  rsst_pkg::tan_type             tan_slope,
   input  rsst_pkg::height_type          cell_x,
   input  rsst_pkg::height_type          zone_start,
   input  rsst_pkg::height_type          zone_end,
   output rsst_pkg::cand_type            cand [rsst_pkg::NUM_NEIGHBORS],
   output rsst_pkg::tan_type             tan_out
);

   logic                                zone_ok;
   logic signed [rsst_pkg::DZ_W:0]      diff [rsst_pkg::NUM_NEIGHBORS];
   rsst_pkg::dz_type                    dz_in [rsst_pkg::NUM_NEIGHBORS];
   logic [rsst_pkg::NUM_NEIGHBORS-1:0]  elig_in;

   rsst_pkg::dz_type                    dz_ff [rsst_pkg::NUM_NEIGHBORS];
   logic [rsst_pkg::NUM_NEIGHBORS-1:0]  elig_ff;
   rsst_pkg::tan_type                   tan_dz_ff;

   rsst_pkg::key_type                   key_in [rsst_pkg::NUM_NEIGHBORS];
   rsst_pkg::cand_type                  cand_ff [rsst_pkg::NUM_NEIGHBORS];
   rsst_pkg::tan_type                   tan_key_ff;

   assign zone_ok = (cell_x > zone_start) && (cell_x < zone_end);

   // drop is exact in one extra bit; only strictly lower neighbours count
   always_comb begin
      for (int k = 0; k < rsst_pkg::NUM_NEIGHBORS; k++) begin
         diff[k]    = {center_height[rsst_pkg::HEIGHT_W-1], center_height}
                    - {neighbor[k][rsst_pkg::HEIGHT_W-1], neighbor[k]};
         dz_in[k]   = diff[k][rsst_pkg::DZ_W-1:0];
         elig_in[k] = neighbor_valid[k] && !diff[k][rsst_pkg::DZ_W] && (diff[k] != '0)
                   && zone_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[rsst_pkg::S_DZ]) begin
         dz_ff     <= dz_in;
         elig_ff   <= elig_in;
         tan_dz_ff <= tan_slope;
      end
   end

   // diagonal keys scale by 1/sqrt2, cardinal keys by one; ineligible ones never win
   always_comb begin
      for (int k = 0; k < rsst_pkg::NUM_NEIGHBORS; k++) begin
         if (!elig_ff[k]) begin
            key_in[k] = '0;
         end else if (rsst_pkg::DIAG_MASK[k]) begin
            key_in[k] = rsst_pkg::KEY_W'(dz_ff[k]) * rsst_pkg::KEY_W'(rsst_pkg::INV_SQRT2_Q30);
         end else begin
            key_in[k] = {dz_ff[k], {rsst_pkg::FRAC_SHIFT{1'b0}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[rsst_pkg::S_KEY]) begin
         for (int k = 0; k < rsst_pkg::NUM_NEIGHBORS; k++) begin
            cand_ff[k].key <= key_in[k];
            cand_ff[k].dz  <= dz_ff[k];
            cand_ff[k].idx <= rsst_pkg::DIR_W'(k);
         end
         tan_key_ff <= tan_dz_ff;
      end
   end

   assign cand    = cand_ff;
   assign tan_out = tan_key_ff;

endmodule

// File: rtl/rsst_argmax.sv
`timescale 1ns / 1ps
// registered three-level tree that picks the steepest neighbour, lower index on ties
// depends on rsst_pkg
module rsst_argmax (
   input  logic                    clock,
   input  rsst_pkg::pipe_ctrl_type ctrl,
   input  rsst_pkg::cand_type      cand [rsst_pkg::NUM_NEIGHBORS],
   input  rsst_pkg::tan_type       tan_in,
   output rsst_pkg::cand_type      best,
   output rsst_pkg::tan_type       tan_out
);

   rsst_pkg::cand_type l1_ff [4];
   rsst_pkg::cand_type l2_ff [2];
   rsst_pkg::cand_type l3_ff;
   rsst_pkg::tan_type  tan_l1_ff;
   rsst_pkg::tan_type  tan_l2_ff;
   rsst_pkg::tan_type  tan_l3_ff;

   // the higher index takes over only on a strictly larger key
   function automatic rsst_pkg::cand_type pick(input rsst_pkg::cand_type lo,
                                               input rsst_pkg::cand_type hi);
      return (hi.key > lo.key) ? hi : lo;
   endfunction

   always_ff @(posedge clock) begin
      if (ctrl.load[rsst_pkg::S_L1]) begin
         for (int i = 0; i < 4; i++) begin
            l1_ff[i] <= pick(cand[2*i], cand[2*i+1]);
         end
         tan_l1_ff <= tan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[rsst_pkg::S_L2]) begin
         for (int i = 0; i < 2; i++) begin
            l2_ff[i] <= pick(l1_ff[2*i], l1_ff[2*i+1]);
         end
         tan_l2_ff <= tan_l1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[rsst_pkg::S_L3]) begin
         l3_ff     <= pick(l2_ff[0], l2_ff[1]);
         tan_l3_ff <= tan_l2_ff;
      end
   end

   assign best    = l3_ff;
   assign tan_out = tan_l3_ff;

endmodule

// File: rtl/rsst_excess.sv
`timescale 1ns / 1ps
// repose distance, excess height and saturated transfer for the chosen neighbour
// depends on rsst_pkg
module rsst_excess (
   input  logic                          clock,
   input  rsst_pkg::pipe_ctrl_type       ctrl,
   input  logic [rsst_pkg::SPACING_W-1:0] grid_spacing,
   input  rsst_pkg::cand_type            best,
   input  rsst_pkg::tan_type             tan_in,
   output logic                          slid,
   output rsst_pkg::dir_type             direction,
   output logic [rsst_pkg::AMOUNT_W-1:0] transfer_amount
);

   localparam int T_W = rsst_pkg::EXCESS_W - 1 - rsst_pkg::TRANSFER_SHIFT;

   logic [rsst_pkg::SPACING_PROD_W-1:0] spacing_prod_ff;
   logic [rsst_pkg::SPACING_PROD_W-1:0] spacing_round;
   logic [rsst_pkg::DIST_W-1:0]         diag_dist_ff;
   logic [rsst_pkg::DIST_W-1:0]         sel_dist;

   logic                                found_ff;
   rsst_pkg::dir_type                   idx_ff;
   rsst_pkg::dz_type                    dz_ff;
   logic [rsst_pkg::PROD_W-1:0]         prod_ff;

   logic signed [rsst_pkg::EXCESS_W-1:0] excess;
   logic [T_W-1:0]                       quarter;
   logic                                 slid_in;
   logic                                 sat;

   logic                                 slid_ff;
   rsst_pkg::dir_type                    dir_ff;
   logic [rsst_pkg::AMOUNT_W-1:0]        amount_ff;

   // diagonal distance follows the spacing register through spacing_prod_ff and diag_dist_ff
   assign spacing_round = spacing_prod_ff
                        + (rsst_pkg::SPACING_PROD_W'(1) << (rsst_pkg::FRAC_SHIFT - 1));

   always_ff @(posedge clock) begin
      spacing_prod_ff <= rsst_pkg::SPACING_PROD_W'(grid_spacing)
                       * rsst_pkg::SPACING_PROD_W'(rsst_pkg::SQRT2_Q30);
      diag_dist_ff    <= spacing_round[rsst_pkg::FRAC_SHIFT +: rsst_pkg::DIST_W];
   end

   assign sel_dist = rsst_pkg::DIAG_MASK[best.idx] ? diag_dist_ff
                                                    : rsst_pkg::DIST_W'(grid_spacing);

   always_ff @(posedge clock) begin
      if (ctrl.load[rsst_pkg::S_MUL]) begin
         found_ff <= (best.key != '0);
         idx_ff   <= best.idx;
         dz_ff    <= best.dz;
         prod_ff  <= rsst_pkg::PROD_W'(tan_in) * rsst_pkg::PROD_W'(sel_dist);
      end
   end

   // excess in signed Q21.28; a quarter of it is the transfer
   assign excess  = $signed(rsst_pkg::EXCESS_W'({dz_ff, {rsst_pkg::TAN_FRAC{1'b0}}}))
                  - $signed(rsst_pkg::EXCESS_W'(prod_ff));
   assign slid_in = found_ff && !excess[rsst_pkg::EXCESS_W-1] && (excess != '0);
   assign quarter = excess[rsst_pkg::EXCESS_W-2:rsst_pkg::TRANSFER_SHIFT];
   assign sat     = |quarter[T_W-1:rsst_pkg::AMOUNT_W];

   always_ff @(posedge clock) begin
      if (ctrl.load[rsst_pkg::S_OUT]) begin
         slid_ff <= slid_in;
         dir_ff  <= slid_in ? idx_ff : '0;
         if (!slid_in) begin
            amount_ff <= '0;
         end else if (sat) begin
            amount_ff <= '1;
         end else begin
            amount_ff <= quarter[rsst_pkg::AMOUNT_W-1:0];
         end
      end
   end

   assign slid            = slid_ff;
   assign direction       = dir_ff;
   assign transfer_amount = amount_ff;

endmodule

// File: rtl/repose_slope_slide_transfer_unit.sv
`timescale 1ns / 1ps
// throughput: one window per cycle, unless the response side holds back and every
// stage is full, through a 7-stage pipeline (drops, keys, three argmax tree levels,
// distance product, excess and saturation); reset clears all stage valid bits and
// restores the three csr registers; the diagonal distance follows a spacing write
// through a registered product and a registered distance
`include "repose_slope_slide_transfer_unit_assert.svh"
module repose_slope_slide_transfer_unit (
   input  logic                              clock,
   input  logic                              reset,
   rsst_req_if.sink                          req_ch,
   rsst_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [rsst_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rsst_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   logic [rsst_pkg::SPACING_W-1:0] grid_spacing_ff;
   rsst_pkg::height_type           zone_start_ff;
   rsst_pkg::height_type           zone_end_ff;

   rsst_pkg::pipe_ctrl_type        ctrl;
   rsst_pkg::height_type           neighbor [rsst_pkg::NUM_NEIGHBORS];
   rsst_pkg::cand_type             cand [rsst_pkg::NUM_NEIGHBORS];
   rsst_pkg::tan_type              tan_key;
   rsst_pkg::cand_type             best;
   rsst_pkg::tan_type              tan_best;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_spacing_ff <= rsst_pkg::SPACING_RESET;
         zone_start_ff   <= rsst_pkg::ZONE_START_RESET;
         zone_end_ff     <= rsst_pkg::ZONE_END_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rsst_pkg::CSR_GRID_SPACING: begin
               grid_spacing_ff <= csr_wr_data[rsst_pkg::SPACING_W-1:0];
            end
            rsst_pkg::CSR_ZONE_START: begin
               zone_start_ff <= $signed(csr_wr_data);
            end
            rsst_pkg::CSR_ZONE_END: begin
               zone_end_ff <= $signed(csr_wr_data);
            end
            default: begin
            end
         endcase
      end
   end

   assign neighbor[0] = req_ch.neighbor_0;
   assign neighbor[1] = req_ch.neighbor_1;
   assign neighbor[2] = req_ch.neighbor_2;
   assign neighbor[3] = req_ch.neighbor_3;
   assign neighbor[4] = req_ch.neighbor_4;
   assign neighbor[5] = req_ch.neighbor_5;
   assign neighbor[6] = req_ch.neighbor_6;
   assign neighbor[7] = req_ch.neighbor_7;

   rsst_pipe_ctrl u_pipe_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .out_ready (rsp_ch.ready),
      .ctrl      (ctrl)
   );

   rsst_key_gen u_key_gen (
      .clock          (clock),
      .ctrl           (ctrl),
      .center_height  (req_ch.center_height),
      .neighbor       (neighbor),
      .neighbor_valid (req_ch.neighbor_valid),
      .tan_slope      (req_ch.tan_slope),
      .cell_x         (req_ch.cell_x),
      .zone_start     (zone_start_ff),
      .zone_end       (zone_end_ff),
      .cand           (cand),
      .tan_out        (tan_key)
   );

   rsst_argmax u_argmax (
      .clock   (clock),
      .ctrl    (ctrl),
      .cand    (cand),
      .tan_in  (tan_key),
      .best    (best),
      .tan_out (tan_best)
   );

   rsst_excess u_excess (
      .clock           (clock),
      .ctrl            (ctrl),
      .grid_spacing    (grid_spacing_ff),
      .best            (best),
      .tan_in          (tan_best),
      .slid            (rsp_ch.slid),
      .direction       (rsp_ch.direction),
      .transfer_amount (rsp_ch.transfer_amount)
   );

   // a beat enters whenever the first stage can load
   assign req_ch.ready = ctrl.load[rsst_pkg::S_DZ];
   assign rsp_ch.valid = ctrl.valid[rsst_pkg::S_OUT];

   `RSST_ASSERT_RST(a_no_slide_zero, clock, reset, rsp_ch.valid && !rsp_ch.slid |-> rsp_ch.direction == '0 && rsp_ch.transfer_amount == '0, "result without slide carries nonzero fields")
   `RSST_ASSERT_RST(a_stall_only_full, clock, reset, !req_ch.ready |-> &ctrl.valid, "input stalled while a pipeline stage is empty")
   `RSST_ASSERT_RST(a_transfer_range, clock, reset, rsp_ch.valid && rsp_ch.slid |-> !rsp_ch.transfer_amount[rsst_pkg::AMOUNT_W-1], "transfer exceeds the reachable range")
   `RSST_ASSERT(a_reset_flush, clock, reset |=> !rsp_ch.valid, "result valid right after reset")

endmodule

// File: tb/rsst_slide_checker.sv
`timescale 1ns / 1ps
// scoreboard for the slide transfer unit: tracks csr writes, predicts every window
// beat and compares response beats in order; depends on rsst_pkg and rsst_if
module rsst_slide_checker (
   input  logic                             clock,
   input  logic                             reset,
   rsst_req_if                              req_mon,
   rsst_rsp_if                              rsp_mon,
   input  logic                             csr_wr_en,
   input  logic [rsst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rsst_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output int                               fault_count,
   output int                               outstanding,
   output int                               checked_count,
   output int                               slid_count
);

   localparam longint INV_ROOT2_Q30 = 759250125;
   localparam longint ROOT2_Q30     = 1518500250;
   localparam longint ROUND_Q30     = 536870912;
   localparam longint AMOUNT_LIMIT  = 2147483647;
   localparam int     TAN_SHIFT     = 12;
   localparam int     QUARTER_SHIFT = 14;
   localparam logic [rsst_pkg::NUM_NEIGHBORS-1:0] DIAGONALS = 8'b1010_0101;

   typedef struct packed {
      logic                          slid;
      rsst_pkg::dir_type             direction;
      logic [rsst_pkg::AMOUNT_W-1:0] amount;
   } slide_result_type;

   slide_result_type expected_slides [$];

   logic [rsst_pkg::SPACING_W-1:0] spacing;
   rsst_pkg::height_type           zone_lo;
   rsst_pkg::height_type           zone_hi;

   function automatic slide_result_type predict_slide(
      input rsst_pkg::height_type               center,
      input rsst_pkg::height_type               heights [rsst_pkg::NUM_NEIGHBORS],
      input logic [rsst_pkg::NUM_NEIGHBORS-1:0] usable,
      input rsst_pkg::tan_type                  tan,
      input rsst_pkg::height_type               x
   );
      slide_result_type r;
      longint drop, best_drop, key, best_key, span_q16, excess, amount;
      int best_dir;
      r = '0;
      if (!(x > zone_lo && x < zone_hi)) return r;
      best_key  = 0;
      best_drop = 0;
      best_dir  = -1;
      for (int k = 0; k < rsst_pkg::NUM_NEIGHBORS; k++) begin
         drop = longint'(center) - longint'(heights[k]);
         if (usable[k] && drop > 0) begin
            // diagonal drops are scaled by 1/sqrt2 so both kinds compare as slopes
            key = DIAGONALS[k] ? drop * INV_ROOT2_Q30 : drop <<< 30;
            if (key > best_key) begin
               best_key  = key;
               best_drop = drop;
               best_dir  = k;
            end
         end
      end
      if (best_dir < 0) return r;
      if (DIAGONALS[best_dir])
         span_q16 = (longint'(spacing) * ROOT2_Q30 + ROUND_Q30) >>> 30;
      else
         span_q16 = longint'(spacing);
      excess = (best_drop <<< TAN_SHIFT) - longint'(tan) * span_q16;
      if (excess > 0) begin
         amount = excess >>> QUARTER_SHIFT;
         if (amount > AMOUNT_LIMIT) amount = AMOUNT_LIMIT;
         r.slid      = 1'b1;
         r.direction = rsst_pkg::dir_type'(best_dir);
         r.amount    = rsst_pkg::AMOUNT_W'(amount);
      end
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rsst_pkg::height_type heights [rsst_pkg::NUM_NEIGHBORS];
      slide_result_type     want;
      if (reset) begin
         spacing       = 31'd65536;
         zone_lo       = 32'sh8000_0000;
         zone_hi       = 32'sh7fff_ffff;
         fault_count   = 0;
         checked_count = 0;
         slid_count    = 0;
         expected_slides.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               rsst_pkg::CSR_GRID_SPACING: spacing = csr_wr_data[rsst_pkg::SPACING_W-1:0];
               rsst_pkg::CSR_ZONE_START:   zone_lo = rsst_pkg::height_type'(csr_wr_data);
               rsst_pkg::CSR_ZONE_END:     zone_hi = rsst_pkg::height_type'(csr_wr_data);
               default: ;
            endcase
         end
         // response first, so a beat never meets its own prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_slides.size() == 0) begin
               $display("%0t: response beat with nothing expected: slid %0d dir %0d amount %0d",
                  $time, rsp_mon.slid, rsp_mon.direction, rsp_mon.transfer_amount);
               fault_count++;
            end else begin
               want = expected_slides.pop_front();
               checked_count++;
               if (want.slid) slid_count++;
               if (rsp_mon.slid !== want.slid) begin
                  $display("%0t: slid mismatch, expected %0d actual %0d",
                     $time, want.slid, rsp_mon.slid);
                  fault_count++;
               end
               if (rsp_mon.direction !== want.direction) begin
                  $display("%0t: direction mismatch, expected %0d actual %0d",
                     $time, want.direction, rsp_mon.direction);
                  fault_count++;
               end
               if (rsp_mon.transfer_amount !== want.amount) begin
                  $display("%0t: transfer_amount mismatch, expected %0d actual %0d",
                     $time, want.amount, rsp_mon.transfer_amount);
                  fault_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            heights[0] = req_mon.neighbor_0;
            heights[1] = req_mon.neighbor_1;
            heights[2] = req_mon.neighbor_2;
            heights[3] = req_mon.neighbor_3;
            heights[4] = req_mon.neighbor_4;
            heights[5] = req_mon.neighbor_5;
            heights[6] = req_mon.neighbor_6;
            heights[7] = req_mon.neighbor_7;
            expected_slides.push_back(predict_slide(req_mon.center_height, heights,
               req_mon.neighbor_valid, req_mon.tan_slope, req_mon.cell_x));
         end
      end
      outstanding = expected_slides.size();
   end

endmodule

// File: tb/tb_repose_slope_slide_transfer_unit.sv
`timescale 1ns / 1ps
// top of the slide transfer testbench: clock, reset, csr setup, window stimulus
// and response pacing; depends on rsst_pkg, rsst_if and rsst_slide_checker
module tb_repose_slope_slide_transfer_unit;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 12;
   localparam int Q16_ONE      = 65536;
   localparam int TAN_ONE      = 4096;
   localparam logic [rsst_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam rsst_pkg::height_type HEIGHT_MAX = 32'sh7fff_ffff;
   localparam rsst_pkg::height_type HEIGHT_MIN = 32'sh8000_0000;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_wr_en;
   logic [rsst_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rsst_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   int fault_count, outstanding, checked_count, slid_count;
   int cycle_count = 0;
   int setting_count;
   int hold_asks = 0;
   bit idle_on;

   // window under construction
   rsst_pkg::height_type               w_center;
   rsst_pkg::height_type               w_nbr [rsst_pkg::NUM_NEIGHBORS];
   logic [rsst_pkg::NUM_NEIGHBORS-1:0] w_mask;
   rsst_pkg::tan_type                  w_tan;
   rsst_pkg::height_type               w_x;

   // what the block was last told, for shaping stimulus
   longint cur_spacing, cur_zone_lo, cur_zone_hi;

   rsst_req_if req_ch ();
   rsst_rsp_if rsp_ch ();

   repose_slope_slide_transfer_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rsst_slide_checker slide_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fault_count   (fault_count),
      .outstanding   (outstanding),
      .checked_count (checked_count),
      .slid_count    (slid_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected", cycle_count, outstanding);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int roll;
      if (!idle_on) return 0;
      roll = int'($urandom_range(0, 99));
      if (roll < 60) return 0;
      if (roll < 93) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 30));
   endfunction

   function automatic rsst_pkg::height_type pick_x();
      longint span;
      span = cur_zone_hi - cur_zone_lo - 1;
      case ($urandom_range(0, 9))
         0: return rsst_pkg::height_type'(cur_zone_lo);
         1: return rsst_pkg::height_type'(cur_zone_lo + 1);
         2: return rsst_pkg::height_type'(cur_zone_hi - 1);
         3: return rsst_pkg::height_type'(cur_zone_hi);
         4: return rsst_pkg::height_type'($urandom);
         default: return (span > 0) ?
            rsst_pkg::height_type'(cur_zone_lo + 1 + longint'($urandom) % span)
            : rsst_pkg::height_type'($urandom);
      endcase
   endfunction

   // response side pacing, with the long hold-off counted here
   initial begin : response_pacer
      int stall;
      int holds_done;
      holds_done   = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_asks != holds_done) begin
            holds_done   = hold_asks;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            stall = pick_gap();
            rsp_ch.ready <= (stall == 0);
            repeat ((stall > 0) ? stall : 1) @(negedge clock);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_window();
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.center_height  <= w_center;
      req_ch.neighbor_0     <= w_nbr[0];
      req_ch.neighbor_1     <= w_nbr[1];
      req_ch.neighbor_2     <= w_nbr[2];
      req_ch.neighbor_3     <= w_nbr[3];
      req_ch.neighbor_4     <= w_nbr[4];
      req_ch.neighbor_5     <= w_nbr[5];
      req_ch.neighbor_6     <= w_nbr[6];
      req_ch.neighbor_7     <= w_nbr[7];
      req_ch.neighbor_valid <= w_mask;
      req_ch.tan_slope      <= w_tan;
      req_ch.cell_x         <= w_x;
      req_ch.valid          <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(input logic [rsst_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rsst_pkg::CSR_DATA_W-1:0]  word);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= word;
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [rsst_pkg::CSR_DATA_W-1:0] spacing_word,
                                input logic [rsst_pkg::CSR_DATA_W-1:0] lo_word,
                                input logic [rsst_pkg::CSR_DATA_W-1:0] hi_word,
                                input bit                              touch_spare);
      wait_drained();
      write_csr(rsst_pkg::CSR_GRID_SPACING, spacing_word);
      write_csr(rsst_pkg::CSR_ZONE_START, lo_word);
      write_csr(rsst_pkg::CSR_ZONE_END, hi_word);
      if (touch_spare) write_csr(CSR_SPARE, $urandom);
      csr_wr_en   <= 1'b0;
      cur_spacing = longint'(spacing_word[rsst_pkg::SPACING_W-1:0]);
      cur_zone_lo = longint'($signed(lo_word));
      cur_zone_hi = longint'($signed(hi_word));
      setting_count++;
      // wait for the diagonal distance to pick up the new spacing
      repeat (3) @(negedge clock);
   endtask

   task automatic clear_window();
      w_center = '0;
      foreach (w_nbr[k]) w_nbr[k] = '0;
      w_mask = '1;
      w_tan  = rsst_pkg::tan_type'(TAN_ONE);
      w_x    = '0;
   endtask

   task automatic make_window();
      int pick, shape;
      longint reach;
      pick   = int'($urandom_range(0, 99));
      w_tan  = (pick < 20) ? rsst_pkg::tan_type'($urandom_range(0, 16'hffff))
                           : rsst_pkg::tan_type'($urandom_range(0, 3 * TAN_ONE));
      w_mask = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : '1;
      w_x    = pick_x();
      if (pick < 15) begin
         w_center = rsst_pkg::height_type'($urandom);
         foreach (w_nbr[k]) w_nbr[k] = rsst_pkg::height_type'($urandom);
      end else begin
         // drops spread around the repose threshold so both outcomes show up
         reach = (longint'(w_tan) * cur_spacing) >>> 12;
         if (reach < 16) reach = 16;
         if (reach > 2 ** 29) reach = 2 ** 29;
         w_center = rsst_pkg::height_type'($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
         foreach (w_nbr[k]) begin
            shape = int'($urandom_range(0, 9));
            case (shape)
               0: w_nbr[k] = rsst_pkg::height_type'(longint'(w_center)
                     + longint'($urandom_range(0, 32'(reach))));
               1: w_nbr[k] = w_center;
               2: w_nbr[k] = (k > 0) ? w_nbr[k-1] : w_center;
               default: w_nbr[k] = rsst_pkg::height_type'(longint'(w_center)
                     - longint'($urandom_range(0, 32'(2 * reach))));
            endcase
         end
      end
   endtask

   task automatic run_random(input int count);
      repeat (count) begin
         make_window();
         send_window();
      end
   endtask

   initial begin : stimulus
      logic [rsst_pkg::CSR_DATA_W-1:0] spacing_word, lo_word, hi_word;
      longint hi_wide;
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_index             = '0;
      csr_wr_data           = '0;
      req_ch.valid          = 1'b0;
      req_ch.center_height  = '0;
      req_ch.neighbor_0     = '0;
      req_ch.neighbor_1     = '0;
      req_ch.neighbor_2     = '0;
      req_ch.neighbor_3     = '0;
      req_ch.neighbor_4     = '0;
      req_ch.neighbor_5     = '0;
      req_ch.neighbor_6     = '0;
      req_ch.neighbor_7     = '0;
      req_ch.neighbor_valid = '0;
      req_ch.tan_slope      = '0;
      req_ch.cell_x         = '0;
      idle_on       = 1'b1;
      setting_count = 1;
      cur_spacing   = Q16_ONE;
      cur_zone_lo   = longint'(HEIGHT_MIN);
      cur_zone_hi   = longint'(HEIGHT_MAX);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners at reset settings: spacing 1.0, zone wide open
      clear_window();
      w_center = HEIGHT_MAX;
      foreach (w_nbr[k]) w_nbr[k] = HEIGHT_MIN;
      w_mask = '0;
      send_window();
      clear_window();
      w_center = HEIGHT_MIN;
      foreach (w_nbr[k]) w_nbr[k] = HEIGHT_MAX;
      send_window();
      clear_window();
      send_window();
      for (int d = 0; d < rsst_pkg::NUM_NEIGHBORS; d++) begin
         clear_window();
         w_nbr[d] = -(2 * Q16_ONE);
         send_window();
      end
      // equal cardinal drops, the earlier one wins
      clear_window();
      w_nbr[1] = -(3 * Q16_ONE);
      w_nbr[3] = -(3 * Q16_ONE);
      send_window();
      // diagonal drops more but is shallower than the cardinal
      clear_window();
      w_nbr[0] = -(4 * Q16_ONE);
      w_nbr[4] = -(3 * Q16_ONE);
      send_window();
      // diagonal steeper than the cardinal
      clear_window();
      w_nbr[7] = -(5 * Q16_ONE);
      w_nbr[6] = -(3 * Q16_ONE);
      send_window();
      // steepest neighbor masked off
      clear_window();
      w_nbr[2] = -(9 * Q16_ONE);
      w_nbr[5] = -Q16_ONE;
      w_mask   = 8'b1111_1011;
      send_window();
      // largest possible drop with zero tangent; saturation is out of reach of these widths
      clear_window();
      w_center = HEIGHT_MAX;
      foreach (w_nbr[k]) w_nbr[k] = HEIGHT_MIN;
      w_tan = '0;
      send_window();
      clear_window();
      w_nbr[6] = -(2 * Q16_ONE);
      w_tan    = '1;
      send_window();
      // slope exactly at repose, then one lsb past it
      clear_window();
      w_nbr[4] = -Q16_ONE;
      send_window();
      clear_window();
      w_nbr[4] = -Q16_ONE - 1;
      send_window();
      // outside the zone at both ends
      clear_window();
      w_nbr[1] = -(2 * Q16_ONE);
      w_x      = HEIGHT_MIN;
      send_window();
      w_x = HEIGHT_MAX;
      send_window();

      // narrow zone around the origin, spare index written too
      apply_setting(32'(Q16_ONE), 32'(-5 * Q16_ONE), 32'(5 * Q16_ONE), 1'b1);
      run_random(80);

      // zero spacing, no idling on either side
      apply_setting('0, HEIGHT_MIN, HEIGHT_MAX, 1'b0);
      idle_on = 1'b0;
      run_random(60);
      idle_on = 1'b1;

      // full-scale spacing, with a long response hold-off and a full drain
      apply_setting(32'h7fff_ffff, HEIGHT_MIN, HEIGHT_MAX, 1'b1);
      run_random(30);
      idle_on = 1'b0;
      hold_asks++;
      run_random(40);
      idle_on = 1'b1;
      wait_drained();
      run_random(30);

      // empty zone: every window lands outside
      apply_setting(32'd1, HEIGHT_MAX, HEIGHT_MIN, 1'b0);
      run_random(30);

      // random settings, top data bit random under the spacing index
      repeat (3) begin
         spacing_word = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 1 << 20))};
         lo_word      = $urandom;
         hi_wide      = longint'($signed(lo_word)) + longint'($urandom_range(2, 1 << 30));
         if (hi_wide > longint'(HEIGHT_MAX)) hi_wide = longint'(HEIGHT_MAX);
         hi_word      = 32'(hi_wide);
         apply_setting(spacing_word, lo_word, hi_word, 1'b0);
         run_random(40);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d windows checked, %0d slid, %0d register settings, %0d mismatches",
         checked_count, slid_count, setting_count, fault_count);
      $display("summary: directed corners, zero and full-scale spacing, empty and narrow zones,"
         , " long response hold-off and full drain");
      if (fault_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rsst_pkg.sv
rtl/rsst_if.sv
rtl/rsst_pipe_ctrl.sv
rtl/rsst_key_gen.sv
rtl/rsst_argmax.sv
rtl/rsst_excess.sv
rtl/repose_slope_slide_transfer_unit.sv
tb/rsst_slide_checker.sv
tb/tb_repose_slope_slide_transfer_unit.sv
